// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by serial_register_access_master_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check that one condition implies another in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/sram_pkg.sv =====
package sram_pkg;

    localparam int REG_COUNT_DEF = 25;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;
    localparam int SHIFT_W       = 40;

    localparam logic [7:0] READ_FLAG = 8'h80;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register size in bytes; addresses past the documented table use four.
    localparam logic [2:0] SIZE_TABLE [32] = '{
        3'd1, 3'd3, 3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd2,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_INST_LO = 3'd1,
        PH_INST_HI = 3'd2,
        PH_DATA_LO = 3'd3,
        PH_DATA_HI = 3'd4,
        PH_FINISH  = 3'd5
    } t_phase;

    typedef struct packed {
        logic              chip_select_n;
        logic              serial_clock;
        logic              sdio_out;
        logic              sdio_drive;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] read_data;
        logic              bad_address;
    } t_result;

endpackage

// ===== hw/rtl/serial_register_access_master_core.sv =====
// An accepted tick's result is registered in the output or the skid register.
// Throughput: one tick per clock cycle unless o_stall is high; a transaction
//   spans 2*(8+8*size)+1 ticks plus the start tick, set by the phase sequencer
//   stepping once per tick. A two-entry output stage (result register plus skid
//   register) keeps the input side free of the output stall path.
// Reset (i_rst_n low, synchronous): phase returns to idle, output stage empties.
`include "assert_macros.svh"

module serial_register_access_master_core #(
    parameter int REG_COUNT = sram_pkg::REG_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // tick transaction in
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_opcode,
    input  logic [sram_pkg::ADDR_W-1:0] i_address,
    input  logic [sram_pkg::DATA_W-1:0] i_write_data,
    input  logic                       i_sdio_in,
    // result transaction out
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_chip_select_n,
    output logic                       o_serial_clock,
    output logic                       o_sdio_out,
    output logic                       o_sdio_drive,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic [sram_pkg::DATA_W-1:0] o_read_data,
    output logic                       o_bad_address
);
    import sram_pkg::*;

    // Sequencer state
    t_phase               r_phase, n_phase;
    logic [5:0]           r_bits_left, n_bits_left;
    logic [SHIFT_W-1:0]   r_out_shift, n_out_shift;
    logic [DATA_W-1:0]    r_in_shift, n_in_shift;
    logic                 r_reading, n_reading;
    logic [2:0]           r_data_bytes, n_data_bytes;

    // Output stage
    t_result              r_out, r_skid, n_result;
    logic                 r_out_valid, r_skid_valid;

    logic                 in_fire;
    logic                 out_take;
    logic                 start_req;
    logic                 addr_bad;
    logic [2:0]           start_size;
    logic [7:0]           instr_byte;
    logic [DATA_W-1:0]    wdata_aligned;
    logic                 top_bit;
    logic [5:0]           bits_dec;

    assign o_stall  = r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    assign start_req  = (i_opcode == OP_WRITE) || (i_opcode == OP_READ);
    assign addr_bad   = {1'b0, i_address} >= 6'(REG_COUNT);
    assign start_size = SIZE_TABLE[i_address];
    assign instr_byte = 8'(i_address) | ((i_opcode == OP_READ) ? READ_FLAG : 8'h00);
    assign top_bit    = r_out_shift[SHIFT_W-1];
    assign bits_dec   = r_bits_left - 6'd1;

    // Left-justify the register's low bytes so the MSB goes out first.
    always_comb begin
        case (start_size)
            3'd1:    wdata_aligned = {i_write_data[7:0], 24'h0};
            3'd2:    wdata_aligned = {i_write_data[15:0], 16'h0};
            3'd3:    wdata_aligned = {i_write_data[23:0], 8'h0};
            default: wdata_aligned = i_write_data;
        endcase
    end

    // Next state and sequencer datapath
    always_comb begin
        n_phase      = r_phase;
        n_bits_left  = r_bits_left;
        n_out_shift  = r_out_shift;
        n_in_shift   = r_in_shift;
        n_reading    = r_reading;
        n_data_bytes = r_data_bytes;
        unique case (r_phase)
            PH_INST_LO: begin
                n_phase = PH_INST_HI;
            end
            PH_INST_HI: begin
                n_out_shift = {r_out_shift[SHIFT_W-2:0], 1'b0};
                if (bits_dec == 6'd0) begin
                    n_bits_left = {r_data_bytes, 3'b000};
                    n_phase     = PH_DATA_LO;
                end else begin
                    n_bits_left = bits_dec;
                    n_phase     = PH_INST_LO;
                end
            end
            PH_DATA_LO: begin
                if (r_reading) begin
                    n_in_shift = {r_in_shift[DATA_W-2:0], i_sdio_in};
                end
                n_phase = PH_DATA_HI;
            end
            PH_DATA_HI: begin
                if (!r_reading) begin
                    n_out_shift = {r_out_shift[SHIFT_W-2:0], 1'b0};
                end
                n_bits_left = bits_dec;
                n_phase     = (bits_dec == 6'd0) ? PH_FINISH : PH_DATA_LO;
            end
            PH_FINISH: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
                if (start_req && !addr_bad) begin
                    n_reading    = (i_opcode == OP_READ);
                    n_data_bytes = start_size;
                    n_bits_left  = 6'd8;
                    n_in_shift   = '0;
                    n_out_shift  = {instr_byte,
                                    (i_opcode == OP_READ) ? {DATA_W{1'b0}} : wdata_aligned};
                    n_phase      = PH_INST_LO;
                end
            end
        endcase
    end

    // Pin levels and flags for this tick
    always_comb begin
        n_result = '{chip_select_n: 1'b1, serial_clock: 1'b1, sdio_out: 1'b0,
                     sdio_drive: 1'b1, busy_res: 1'b0, done_res: 1'b0,
                     read_data: '0, bad_address: 1'b0};
        unique case (r_phase)
            PH_INST_LO: begin
                n_result.chip_select_n = 1'b0;
                n_result.serial_clock  = 1'b0;
                n_result.busy_res      = 1'b1;
                n_result.sdio_out      = top_bit;
            end
            PH_INST_HI: begin
                n_result.chip_select_n = 1'b0;
                n_result.busy_res      = 1'b1;
                n_result.sdio_out      = top_bit;
            end
            PH_DATA_LO: begin
                n_result.chip_select_n = 1'b0;
                n_result.serial_clock  = 1'b0;
                n_result.busy_res      = 1'b1;
                n_result.sdio_drive    = !r_reading;
                n_result.sdio_out      = !r_reading && top_bit;
            end
            PH_DATA_HI: begin
                n_result.chip_select_n = 1'b0;
                n_result.busy_res      = 1'b1;
                n_result.sdio_drive    = !r_reading;
                n_result.sdio_out      = !r_reading && top_bit;
            end
            PH_FINISH: begin
                n_result.done_res  = 1'b1;
                n_result.read_data = r_reading ? r_in_shift : '0;
            end
            default: begin
                if (start_req) begin
                    if (addr_bad) begin
                        n_result.bad_address = 1'b1;
                    end else begin
                        n_result.chip_select_n = 1'b0;
                        n_result.busy_res      = 1'b1;
                    end
                end
            end
        endcase
    end

    // Advance the sequencer on every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (in_fire) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_bits_left  <= n_bits_left;
            r_out_shift  <= n_out_shift;
            r_in_shift   <= n_in_shift;
            r_reading    <= n_reading;
            r_data_bytes <= n_data_bytes;
        end
    end

    // Output register with skid: hold a result in the skid register when the
    // output register is full and stalled, drain it first when the sink frees up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_fire) begin
            r_skid <= n_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_chip_select_n = r_out.chip_select_n;
    assign o_serial_clock  = r_out.serial_clock;
    assign o_sdio_out      = r_out.sdio_out;
    assign o_sdio_drive    = r_out.sdio_drive;
    assign o_busy_res      = r_out.busy_res;
    assign o_done_res      = r_out.done_res;
    assign o_read_data     = r_out.read_data;
    assign o_bad_address   = r_out.bad_address;

    // The skid register only fills behind a full output register.
    `ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid register holds a result while the output register is empty")
    // Every bit phase has at least one bit still to move.
    `ASSERT_IMPL(a_bits_left_live, i_clk, i_rst_n,
        (r_phase == PH_INST_LO || r_phase == PH_INST_HI ||
         r_phase == PH_DATA_LO || r_phase == PH_DATA_HI),
        r_bits_left != 6'd0, "bit phase entered with no bits left")
    // A finishing tick is never reported as busy.
    `ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_out.done_res,
        !r_out.busy_res && r_out.chip_select_n, "done result still shows busy")
    // A rejected start leaves the bus idle.
    `ASSERT_IMPL(a_bad_keeps_idle, i_clk, i_rst_n, in_fire && n_result.bad_address,
        n_phase == PH_IDLE, "rejected start left the idle phase")

endmodule

// ===== tb/sram_tb_pkg.sv =====
`timescale 1ns / 100ps

package sram_tb_pkg;

    import sram_pkg::*;

    // Shadow of the serial master: steps once per accepted tick and queues the
    // levels that the block should present for that tick.
    class tick_scoreboard;

        t_phase      phase;
        logic [5:0]  bits_left;
        logic [39:0] out_shift;
        logic [31:0] in_shift;
        logic        reading;
        logic [2:0]  data_bytes;

        t_result     pending[$];

        int errors;
        int ticks_noted;
        int results_checked;
        int writes_started;
        int reads_started;
        int rejects;

        function new();
            phase           = PH_IDLE;
            bits_left       = '0;
            out_shift       = '0;
            in_shift        = '0;
            reading         = 1'b0;
            data_bytes      = '0;
            errors          = 0;
            ticks_noted     = 0;
            results_checked = 0;
            writes_started  = 0;
            reads_started   = 0;
            rejects         = 0;
        endfunction

        // Register width in bytes as SIZE_TABLE in sram_pkg defines it.
        static function int unsigned reg_bytes(logic [ADDR_W-1:0] addr);
            case (addr)
                5'd0:    return 1;
                5'd1:    return 3;
                5'd2:    return 2;
                5'd3:    return 3;
                5'd5:    return 2;
                5'd6:    return 3;
                5'd7:    return 2;
                default: return 4;
            endcase
        endfunction

        function void note_tick(logic [1:0] opcode, logic [ADDR_W-1:0] addr,
                                logic [DATA_W-1:0] wdata, logic sdio);
            t_result r;
            int unsigned nbytes;
            r               = '0;
            r.chip_select_n = 1'b1;
            r.serial_clock  = 1'b1;
            r.sdio_drive    = 1'b1;
            ticks_noted++;
            case (phase)
                PH_INST_LO: begin
                    r.chip_select_n = 1'b0;
                    r.serial_clock  = 1'b0;
                    r.busy_res      = 1'b1;
                    r.sdio_out      = out_shift[39];
                    phase           = PH_INST_HI;
                end
                PH_INST_HI: begin
                    r.chip_select_n = 1'b0;
                    r.busy_res      = 1'b1;
                    r.sdio_out      = out_shift[39];
                    out_shift       = out_shift << 1;
                    bits_left       = bits_left - 6'd1;
                    if (bits_left == 6'd0) begin
                        bits_left = {data_bytes, 3'b000};
                        phase     = PH_DATA_LO;
                    end else begin
                        phase = PH_INST_LO;
                    end
                end
                PH_DATA_LO: begin
                    r.chip_select_n = 1'b0;
                    r.serial_clock  = 1'b0;
                    r.busy_res      = 1'b1;
                    if (reading) begin
                        r.sdio_drive = 1'b0;
                        in_shift     = {in_shift[30:0], sdio};
                    end else begin
                        r.sdio_out = out_shift[39];
                    end
                    phase = PH_DATA_HI;
                end
                PH_DATA_HI: begin
                    r.chip_select_n = 1'b0;
                    r.busy_res      = 1'b1;
                    if (reading) begin
                        r.sdio_drive = 1'b0;
                    end else begin
                        r.sdio_out = out_shift[39];
                        out_shift  = out_shift << 1;
                    end
                    bits_left = bits_left - 6'd1;
                    phase     = (bits_left == 6'd0) ? PH_FINISH : PH_DATA_LO;
                end
                PH_FINISH: begin
                    r.done_res = 1'b1;
                    if (reading)
                        r.read_data = in_shift;
                    phase = PH_IDLE;
                end
                default: begin
                    phase = PH_IDLE;
                    if (opcode == OP_WRITE || opcode == OP_READ) begin
                        if (addr >= REG_COUNT_DEF) begin
                            r.bad_address = 1'b1;
                            rejects++;
                        end else begin
                            nbytes     = reg_bytes(addr);
                            reading    = (opcode == OP_READ);
                            data_bytes = nbytes[2:0];
                            bits_left  = 6'd8;
                            in_shift   = '0;
                            out_shift  = '0;
                            out_shift[39:32] = {3'b000, addr} | (reading ? READ_FLAG : 8'h00);
                            if (!reading)
                                out_shift[31:0] = wdata << (32 - 8 * nbytes);
                            phase           = PH_INST_LO;
                            r.chip_select_n = 1'b0;
                            r.busy_res      = 1'b1;
                            if (reading)
                                reads_started++;
                            else
                                writes_started++;
                        end
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result with no tick pending: expected none, actual %0h",
                         $time, got);
                return;
            end
            want = pending.pop_front();
            results_checked++;
            compare("chip_select_n", want.chip_select_n, got.chip_select_n);
            compare("serial_clock",  want.serial_clock,  got.serial_clock);
            compare("sdio_out",      want.sdio_out,      got.sdio_out);
            compare("sdio_drive",    want.sdio_drive,    got.sdio_drive);
            compare("busy_res",      want.busy_res,      got.busy_res);
            compare("done_res",      want.done_res,      got.done_res);
            compare("read_data",     want.read_data,     got.read_data);
            compare("bad_address",   want.bad_address,   got.bad_address);
        endfunction

    endclass

endpackage

// ===== tb/tb_serial_register_access_master_core.sv =====
`timescale 1ns / 100ps

module tb_serial_register_access_master_core;

    import sram_pkg::*;
    import sram_tb_pkg::*;

    // Opcode 3 has no function of its own; the block treats it as a plain tick.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Data line patterns for the ticks of one transaction.
    localparam int SDIO_LOW    = 0;
    localparam int SDIO_HIGH   = 1;
    localparam int SDIO_RANDOM = 2;

    localparam int RANDOM_TICKS = 450;
    localparam int HOLD_AT      = 500;   // ticks noted before the long hold-off
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 200000;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic [1:0]          i_opcode     = OP_TICK;
    logic [ADDR_W-1:0]   i_address    = '0;
    logic [DATA_W-1:0]   i_write_data = '0;
    logic                i_sdio_in    = 1'b0;
    logic                i_stall      = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                o_chip_select_n;
    logic                o_serial_clock;
    logic                o_sdio_out;
    logic                o_sdio_drive;
    logic                o_busy_res;
    logic                o_done_res;
    logic [DATA_W-1:0]   o_read_data;
    logic                o_bad_address;

    tick_scoreboard sb = new();

    int      burst_left = 0;
    int      cycle_count = 0;
    int      rx_cycle = 0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    t_result rx_result;

    serial_register_access_master_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_sdio_in       (i_sdio_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_chip_select_n (o_chip_select_n),
        .o_serial_clock  (o_serial_clock),
        .o_sdio_out      (o_sdio_out),
        .o_sdio_drive    (o_sdio_drive),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_read_data     (o_read_data),
        .o_bad_address   (o_bad_address)
    );

    always #4 i_clk = ~i_clk;

    // Offer one tick and hold it until the block takes it. The sender runs in
    // bursts; between bursts it drops valid for a random gap, and a quarter of
    // the bursts follow the previous one with no gap at all.
    task automatic drive_tick(logic [1:0] opcode, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] wdata, logic sdio);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_opcode     <= opcode;
        i_address    <= addr;
        i_write_data <= wdata;
        i_sdio_in    <= sdio;
        // The transaction is taken at the first edge with stall low.
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_tick(opcode, addr, wdata, sdio);
    endtask

    function automatic logic pick_sdio(int mode);
        if (mode == SDIO_LOW)
            return 1'b0;
        if (mode == SDIO_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // Tick with nothing to start: opcode 0 or the spare code, random payload.
    task automatic idle_tick();
        drive_tick($urandom_range(0, 1) ? OP_TICK : OP_SPARE,
                   ADDR_W'($urandom), $urandom, 1'($urandom));
    endtask

    // One full register access: the start tick, two ticks per bit of the
    // instruction and data, then the finish tick. With busy_noise set, the
    // ticks in flight carry random opcodes, so starts land while busy and on
    // the finish tick, where they must be dropped.
    task automatic run_access(logic [1:0] opcode, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] wdata, int sdio_mode,
                              bit busy_noise);
        int bit_ticks;
        bit_ticks = 2 * (8 + 8 * tick_scoreboard::reg_bytes(addr));
        drive_tick(opcode, addr, wdata, pick_sdio(sdio_mode));
        repeat (bit_ticks)
            drive_tick(busy_noise ? 2'($urandom_range(0, 3)) : OP_TICK,
                       ADDR_W'($urandom), $urandom, pick_sdio(sdio_mode));
        drive_tick(busy_noise ? ($urandom_range(0, 1) ? OP_WRITE : OP_READ) : OP_TICK,
                   ADDR_W'($urandom_range(0, 24)), $urandom, pick_sdio(sdio_mode));
    endtask

    // Receiver: check every result taken, then pick the stall level for the
    // next cycle. The pattern cycles through no stall, light and heavy random
    // stall and a periodic stall; once, mid-run, hold off for a long stretch
    // so the output stage fills and the block stalls its input.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            rx_result.chip_select_n = o_chip_select_n;
            rx_result.serial_clock  = o_serial_clock;
            rx_result.sdio_out      = o_sdio_out;
            rx_result.sdio_drive    = o_sdio_drive;
            rx_result.busy_res      = o_busy_res;
            rx_result.done_res      = o_done_res;
            rx_result.read_data     = o_read_data;
            rx_result.bad_address   = o_bad_address;
            sb.check_result(rx_result);
        end
        rx_cycle++;
        if (!hold_done && sb.ticks_noted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case ((rx_cycle / 97) % 4)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 9) < 6);
                default: i_stall <= (rx_cycle % 3 == 0);
            endcase
        end
    end

    // Watchdog: end the run if it stalls for any reason.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int target;
        int kind;
        // Hold reset, then release it on an edge so driving stays edge aligned.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: plain and spare ticks in idle, rejected addresses at both
        // ends of the out-of-range span, the last valid register, each size,
        // data lines stuck low and high, and starts while busy.
        drive_tick(OP_TICK, '0, '0, 1'b0);
        drive_tick(OP_SPARE, '1, '1, 1'b1);
        drive_tick(OP_WRITE, 5'd31, '1, 1'b1);
        drive_tick(OP_READ, 5'd25, '0, 1'b0);
        run_access(OP_WRITE, 5'd24, 32'hFFFF_FFFF, SDIO_HIGH, 1'b0);
        run_access(OP_READ, 5'd24, 32'h0000_0000, SDIO_HIGH, 1'b0);
        run_access(OP_WRITE, 5'd0, 32'hFFFF_FFA5, SDIO_LOW, 1'b0);
        run_access(OP_READ, 5'd0, 32'hFFFF_FFFF, SDIO_LOW, 1'b1);
        run_access(OP_WRITE, 5'd1, 32'hA5C3_5A3C, SDIO_RANDOM, 1'b1);
        run_access(OP_READ, 5'd2, 32'h0000_0000, SDIO_RANDOM, 1'b1);
        run_access(OP_WRITE, 5'd4, 32'h0000_0000, SDIO_HIGH, 1'b0);
        run_access(OP_READ, 5'd3, 32'h0000_0000, SDIO_RANDOM, 1'b0);
        drive_tick(OP_READ, 5'd24, '0, 1'b1);
        repeat (48) drive_tick(OP_TICK, '0, '0, 1'b1);
        drive_tick(OP_TICK, '0, '0, 1'b0);

        // Random: mostly complete accesses with random content, back to back
        // or separated by a few idle ticks, with some rejected starts between.
        target = sb.ticks_noted + RANDOM_TICKS;
        while (sb.ticks_noted < target) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                drive_tick($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                           ADDR_W'($urandom_range(REG_COUNT_DEF, 31)), $urandom,
                           1'($urandom));
            end else begin
                run_access($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                           ADDR_W'($urandom_range(0, REG_COUNT_DEF - 1)), $urandom,
                           $urandom_range(SDIO_LOW, SDIO_RANDOM),
                           $urandom_range(0, 3) != 0);
            end
            repeat ($urandom_range(0, 2)) idle_tick();
        end
        i_valid <= 1'b0;

        // Drain, then leave room for any stray result to show up.
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d ticks: %0d writes, %0d reads, %0d rejected starts.",
                 sb.ticks_noted, sb.writes_started, sb.reads_started, sb.rejects);
        $display("Checked %0d results field by field, %0d mismatches.",
                 sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
